/* rtl/rxipd_pkg.sv */
// ----------------------------------------------------------------------------
// rxipd_pkg
// Shared codes, character constants and result-word bit positions for the
// receive FIFO with "+IPD," frame extractor.
// ----------------------------------------------------------------------------
package rxipd_pkg;

  // Operation codes carried with each input item.
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Detector phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_I     = 3'd1;
  localparam logic [2:0] PH_P     = 3'd2;
  localparam logic [2:0] PH_D     = 3'd3;
  localparam logic [2:0] PH_COMMA = 3'd4;
  localparam logic [2:0] PH_LEN   = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int          LEN_W   = 16;
  localparam logic [19:0] LEN_SAT = 20'd65535;
  localparam int          INDEX_W = 9;

  // Bit positions of the flags in the result tuser.
  localparam int USER_STORED  = 0;
  localparam int USER_RD_VLD  = 1;
  localparam int USER_PAY_VLD = 2;
  localparam int USER_ABORT   = 3;
  localparam int USER_W       = 4;

  // Flags of one result while it waits for the memory read data.
  typedef struct packed {
    logic stored;
    logic rd_valid;
    logic pay_valid;
    logic pay_last;
    logic abort;
  } flags_t;

  // Character expected in each header phase.
  function automatic logic [7:0] pattern_char(input logic [2:0] ph);
    logic [7:0] c;
    unique case (ph)
      PH_IDLE:  c = CHAR_PLUS;
      PH_I:     c = CHAR_I;
      PH_P:     c = CHAR_P;
      PH_D:     c = CHAR_D;
      PH_COMMA: c = CHAR_COMMA;
      default:  c = CHAR_PLUS;
    endcase
    return c;
  endfunction

endpackage

/* rtl/rxipd_ram.sv */
// ----------------------------------------------------------------------------
// rxipd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rxipd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rx_fifo_with_ipd_frame_extractor_top.sv */
// ----------------------------------------------------------------------------
// rx_fifo_with_ipd_frame_extractor_top
// Receive byte FIFO in synchronous RAM with an inline "+IPD,<len>:" frame
// detector that streams the frame payload out alongside each result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                        Contents
//  --------  ---------  -----------------------------  --------------------------
//  in_       slave      tvalid tready tdata tuser      one operation per item
//  out_      master     tvalid tready tdata tuser tlast  one result per item
//
// Each accepted item yields one result through the FIFO RAM's registered read stage,
// then the output register; a new item can be accepted every cycle while in_tready is high.
// Pointer, count and detector state update at the accepting edge, so items never
// wait on each other. A stalled output parks one result in the output register
// and the next in the RAM read stage; in_tready drops only when both are full.
// Reset clears pointers, count, detector and stage valids, and holds in_tready low.
//
module rx_fifo_with_ipd_frame_extractor_top
  import rxipd_pkg::*;
#(
  parameter int FIFO_DEPTH  = 256,
  parameter int MAX_PAYLOAD = 512,
  localparam int CW         = $clog2(FIFO_DEPTH + 1),
  localparam int OUT_DATA_W = ((8 + 8 + INDEX_W + CW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic [1:0]            in_tuser,   // [1:0] op
  // Result item.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] read_byte, [15:8] payload_byte, [24:16] payload_index,
  // then fifo_level, zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] stored, [1] read_valid, [2] payload_valid, [3] frame_abort
  output logic [USER_W-1:0]     out_tuser,
  output logic                  out_tlast   // payload_last
);

  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int PCW = $clog2(MAX_PAYLOAD + 1);

  // Architectural state.
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] exp_len_r, exp_len_nxt;
  logic [PCW-1:0]   pay_cnt_r, pay_cnt_nxt;

  // RAM read stage: result fields waiting for the read data.
  logic               s1_valid_r, s1_valid_nxt;
  flags_t             s1_flags_r, flags;
  logic [7:0]         s1_pbyte_r;
  logic [INDEX_W-1:0] s1_index_r, pay_index;
  logic [CW-1:0]      s1_level_r;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [USER_W-1:0]     out_user_r;
  logic                  out_last_r;

  logic          accept, out_adv;
  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;
  logic [PCW-1:0] cnt_inc;
  logic [19:0]   len_calc;
  logic [31:0]   pay_cnt_ext;
  logic [7:0]    read_byte;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || out_adv);
  assign accept    = in_tvalid && in_tready;

  assign cnt_inc     = pay_cnt_r + PCW'(1);
  assign pay_cnt_ext = 32'(pay_cnt_r);
  assign pay_index   = pay_cnt_ext[INDEX_W-1:0];
  // Decimal accumulate: len * 10 + digit, before saturation.
  assign len_calc = ({4'd0, exp_len_r} << 3) + ({4'd0, exp_len_r} << 1)
                  + 20'(4'(in_tdata - CHAR_ZERO));

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    exp_len_nxt = exp_len_r;
    pay_cnt_nxt = pay_cnt_r;
    flags       = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (accept) begin
      unique case (in_tuser)
        OP_RECEIVE: begin
          // FIFO push; a full FIFO drops the byte but the detector sees it.
          if (count_r != CW'(FIFO_DEPTH)) begin
            ram_we       = 1'b1;
            wr_ptr_nxt   = (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
            count_nxt    = count_r + CW'(1);
            flags.stored = 1'b1;
          end
          unique case (phase_r) inside
            PH_IDLE: begin
              if (in_tdata == CHAR_PLUS) begin
                phase_nxt   = PH_I;
                pay_cnt_nxt = '0;
                exp_len_nxt = '0;
              end
            end
            PH_I, PH_P, PH_D, PH_COMMA: begin
              // A mismatch goes back to idle without rechecking the byte.
              if (in_tdata == pattern_char(phase_r)) begin
                phase_nxt = phase_r + 3'd1;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_LEN: begin
              if (in_tdata >= CHAR_ZERO && in_tdata <= CHAR_NINE) begin
                exp_len_nxt = (len_calc > LEN_SAT) ? LEN_SAT[LEN_W-1:0]
                                                   : len_calc[LEN_W-1:0];
              end else if (in_tdata == CHAR_COLON) begin
                phase_nxt   = PH_DATA;
                pay_cnt_nxt = '0;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_DATA: begin
              if (pay_cnt_ext < 32'(MAX_PAYLOAD)) begin
                flags.pay_valid = 1'b1;
                pay_cnt_nxt     = cnt_inc;
                // A zero length also ends here, after the first byte.
                if (32'(cnt_inc) >= 32'(exp_len_r)) begin
                  flags.pay_last = 1'b1;
                  phase_nxt      = PH_IDLE;
                end
              end else begin
                flags.abort = 1'b1;
                phase_nxt   = PH_IDLE;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
        OP_READ: begin
          if (count_r != '0) begin
            ram_re         = 1'b1;
            rd_ptr_nxt     = (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
            count_nxt      = count_r - CW'(1);
            flags.rd_valid = 1'b1;
          end
        end
        OP_CLEAR: begin
          wr_ptr_nxt = '0;
          rd_ptr_nxt = '0;
          count_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // A read only ever reaches an entry written at an earlier edge, so no forwarding is needed.
  rxipd_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign s1_valid_nxt = accept || (s1_valid_r && !out_adv);
  assign read_byte    = s1_flags_r.rd_valid ? ram_rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      phase_r     <= PH_IDLE;
      exp_len_r   <= '0;
      pay_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
      phase_r    <= phase_nxt;
      exp_len_r  <= exp_len_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= flags;
      s1_pbyte_r <= flags.pay_valid ? in_tdata : 8'd0;
      s1_index_r <= flags.pay_valid ? pay_index : '0;
      s1_level_r <= count_nxt;
    end
    if (out_adv && s1_valid_r) begin
      out_data_r <= OUT_DATA_W'({s1_level_r, s1_index_r, s1_pbyte_r, read_byte});
      out_user_r <= {s1_flags_r.abort, s1_flags_r.pay_valid,
                     s1_flags_r.rd_valid, s1_flags_r.stored};
      out_last_r <= s1_flags_r.pay_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/rxipd_checker.sv */
// ----------------------------------------------------------------------------
// rxipd_checker
// Port-level checks for the receive FIFO with frame extractor, bound to the
// top level.
// ----------------------------------------------------------------------------
module rxipd_checker
  import rxipd_pkg::*;
#(
  parameter int OUT_DATA_W = 40
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [USER_W-1:0]     out_tuser,
  input logic                  out_tlast
);

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The end of a frame is always a payload byte.
  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[USER_PAY_VLD])
    else $error("frame end without payload byte");

  // One item cannot both push and pop, nor be payload and abort the frame.
  a_exclusive_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[USER_STORED] && out_tuser[USER_RD_VLD])
      && !(out_tuser[USER_PAY_VLD] && out_tuser[USER_ABORT]))
    else $error("conflicting result flags");

  // An empty read returns a zero byte.
  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USER_RD_VLD] |-> out_tdata[7:0] == 8'd0)
    else $error("read byte set without a pop");

endmodule

bind rx_fifo_with_ipd_frame_extractor_top rxipd_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_rxipd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
